// ===== design/matrix_keypad_scanner_with_repeat_defines.svh =====
// ----------------------------------------------------------------------------
// Keypad scanner assertion macros
// Concurrent checks on clk_i with reset rst_ni; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_SCANNER_WITH_REPEAT_DEFINES_SVH
`define MATRIX_KEYPAD_SCANNER_WITH_REPEAT_DEFINES_SVH

`ifndef SYNTHESIS
// assert that prop holds at every clock outside reset
`define KPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// assert that cond never holds outside reset
`define KPR_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define KPR_ASSERT(label, prop, msg)
`define KPR_NEVER(label, cond, msg)
`endif

`endif

// ===== design/kpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Keypad scanner package
// Shared types, register codes and reset values of the keypad scanner.
// ----------------------------------------------------------------------------
package kpr_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 64;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned MASK_W         = 16;
  localparam int unsigned LEVEL_W        = 7;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned DELAY_W        = 8;
  localparam int unsigned NUM_KEYMAP     = 4;

  localparam logic [MASK_W-1:0]  SENSE_FLIP       = 16'h8888;
  localparam logic [DELAY_W-1:0] FIRST_DELAY_RST  = 8'd20;
  localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST = 8'd2;
  localparam logic [NUM_KEYMAP-1:0][CFG_DATA_W-1:0] KEYMAP_RST = {
    32'd875640618, 32'd892483632, 32'd909326602, 32'd1650549604
  };

  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEYMAP_0     = 3'd0,
    CFG_KEYMAP_1     = 3'd1,
    CFG_KEYMAP_2     = 3'd2,
    CFG_KEYMAP_3     = 3'd3,
    CFG_FIRST_DELAY  = 3'd4,
    CFG_REPEAT_DELAY = 3'd5
  } kpr_cfg_e;

  typedef struct packed {
    logic              is_read;
    logic [CHAR_W-1:0] ch;
    logic [MASK_W-1:0] mask;
  } kpr_op_t;

  typedef struct packed {
    logic               char_valid;
    logic               key_accepted;
    logic               key_dropped;
    logic [LEVEL_W-1:0] level;
    logic [MASK_W-1:0]  mask;
  } kpr_res_t;

endpackage

// ===== design/kpr_ram.sv =====
// ----------------------------------------------------------------------------
// Keypad scanner RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module kpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/kpr_queue.sv =====
// ----------------------------------------------------------------------------
// Keypad scanner word queue
// Two-word queue between the classifying front and the FIFO back end.
// ----------------------------------------------------------------------------
module kpr_queue
  import kpr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  input  kpr_op_t push_data_i,
  output logic    push_ready_o,
  output logic    pop_valid_o,
  output kpr_op_t pop_data_o,
  input  logic    pop_ready_i
);

  kpr_op_t     slot_q [2];
  logic        wr_q, wr_d;
  logic        rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/kpr_front.sv =====
// ----------------------------------------------------------------------------
// Keypad scanner front end
// Holds the registers, decodes the key mask, runs the repeat countdown
// and hands one classified word per accepted item to the queue.
// ----------------------------------------------------------------------------
`include "matrix_keypad_scanner_with_repeat_defines.svh"

module kpr_front
  import kpr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [MASK_W-1:0]     row_sense_i,
  output logic                  op_valid_o,
  output kpr_op_t               op_o,
  input  logic                  op_ready_i
);

  logic [NUM_KEYMAP-1:0][CFG_DATA_W-1:0] keymap_q;
  logic [DELAY_W-1:0] first_q, repeat_q;
  logic [MASK_W-1:0]  last_q, last_d;
  logic [DELAY_W-1:0] cnt_q, cnt_d;
  logic [MASK_W-1:0]  mask;
  logic               emit;
  logic               in_fire;
  logic [CHAR_W-1:0]  ch;

  function automatic logic [CHAR_W-1:0] lookup_char(
    input logic [MASK_W-1:0] m,
    input logic [NUM_KEYMAP*CFG_DATA_W-1:0] map
  );
    logic [CHAR_W-1:0] c;
    c = '0;
    for (int k = 0; k < MASK_W; k++) begin
      if (m == (MASK_W'(1) << k)) begin
        c = c | map[k*CHAR_W +: CHAR_W];
      end
    end
    return c;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keymap_q <= KEYMAP_RST;
      first_q  <= FIRST_DELAY_RST;
      repeat_q <= REPEAT_DELAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEYMAP_0:     keymap_q[0] <= cfg_wdata_i;
        CFG_KEYMAP_1:     keymap_q[1] <= cfg_wdata_i;
        CFG_KEYMAP_2:     keymap_q[2] <= cfg_wdata_i;
        CFG_KEYMAP_3:     keymap_q[3] <= cfg_wdata_i;
        CFG_FIRST_DELAY:  first_q     <= cfg_wdata_i[DELAY_W-1:0];
        CFG_REPEAT_DELAY: repeat_q    <= cfg_wdata_i[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  assign mask       = ~(row_sense_i ^ SENSE_FLIP);
  assign in_ready_o = op_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    cnt_d  = cnt_q;
    last_d = last_q;
    emit   = 1'b0;
    if (req_type_i == REQ_SCAN) begin
      if (mask != '0) begin
        if (mask != last_q) begin
          cnt_d = first_q;
          emit  = 1'b1;
        end else if (cnt_q <= DELAY_W'(1)) begin
          cnt_d = repeat_q;
          emit  = 1'b1;
        end else begin
          cnt_d = cnt_q - DELAY_W'(1);
        end
      end
      last_d = mask;
    end
  end

  assign ch = emit ? lookup_char(mask, keymap_q) : '0;

  always_comb begin
    op_valid_o   = in_valid_i;
    op_o.is_read = (req_type_i == REQ_READ);
    op_o.ch      = ch;
    op_o.mask    = (req_type_i == REQ_SCAN) ? mask : last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      cnt_q  <= '0;
    end else if (in_fire) begin
      last_q <= last_d;
      cnt_q  <= cnt_d;
    end
  end

  `KPR_ASSERT(a_reload_first, in_fire && (req_type_i == REQ_SCAN) && (mask != '0) && (mask != last_q) |=> cnt_q == $past(first_q), "countdown not reloaded on new key")
  `KPR_ASSERT(a_mask_kept, in_fire && (req_type_i == REQ_SCAN) |=> last_q == $past(mask), "last mask not updated by scan")
  `KPR_NEVER(a_read_no_char, op_valid_o && op_o.is_read && (op_o.ch != '0), "read word carries a character")

endmodule

// ===== design/kpr_back.sv =====
// ----------------------------------------------------------------------------
// Keypad scanner back end
// Character FIFO over a RAM: pushes scan characters, pops on reads and
// holds the result word until it is taken.
// ----------------------------------------------------------------------------
`include "matrix_keypad_scanner_with_repeat_defines.svh"

module kpr_back
  import kpr_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_valid_i,
  input  kpr_op_t           op_i,
  output logic              op_ready_o,
  output logic              res_valid_o,
  output kpr_res_t          res_o,
  output logic [CHAR_W-1:0] res_char_o,
  input  logic              res_ready_i
);

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam int unsigned HW = $clog2(FIFO_DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(FIFO_DEPTH - 1);
  localparam logic [HW-1:0] HELD_MAX = HW'(FIFO_DEPTH);

  logic [AW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [HW-1:0]     held_q, held_d;
  logic              res_valid_q, res_valid_d;
  kpr_res_t          res_q, res_d;
  logic              advance, fire, has_char, push, drop, pop;
  logic [CHAR_W-1:0] rdata;

  assign advance    = !res_valid_q || res_ready_i;
  assign op_ready_o = advance;
  assign fire       = op_valid_i && advance;
  assign has_char   = !op_i.is_read && (op_i.ch != '0);
  assign push       = fire && has_char && (held_q != HELD_MAX);
  assign drop       = fire && has_char && (held_q == HELD_MAX);
  assign pop        = fire && op_i.is_read && (held_q != '0);

  always_comb begin
    wr_d   = push ? ((wr_q == PTR_LAST) ? '0 : wr_q + AW'(1)) : wr_q;
    rd_d   = pop ? ((rd_q == PTR_LAST) ? '0 : rd_q + AW'(1)) : rd_q;
    held_d = held_q + HW'(push) - HW'(pop);
    res_valid_d = advance ? fire : res_valid_q;
    res_d              = res_q;
    if (fire) begin
      res_d.char_valid   = pop;
      res_d.key_accepted = push;
      res_d.key_dropped  = drop;
      res_d.level        = LEVEL_W'(held_d);
      res_d.mask         = op_i.mask;
    end
  end

  kpr_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(FIFO_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wr_q),
    .wdata_i (op_i.ch),
    .re_i    (pop),
    .raddr_i (rd_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q        <= '0;
      rd_q        <= '0;
      held_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      held_q      <= held_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign res_char_o  = res_q.char_valid ? rdata : '0;

  `KPR_ASSERT(a_held_bound, held_q <= HELD_MAX, "held count above depth")
  `KPR_NEVER(a_acc_drop, res_valid_q && res_q.key_accepted && res_q.key_dropped, "word both pushed and dropped")
  `KPR_ASSERT(a_stall_hold, res_valid_q && !res_ready_i |=> $stable(res_char_o), "stalled character changed")

endmodule

// ===== design/matrix_keypad_scanner_with_repeat.sv =====
// ----------------------------------------------------------------------------
// Matrix keypad scanner with typematic repeat
//
//   channel  direction  handshake                  words
//   in       input      in_valid_i / in_ready_o    req_type_i, row_sense_i
//   out      output     out_valid_o / out_ready_i  out_char_o .. pressed_keys_o
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One word per cycle sustained while out_ready_i takes each result; an input
// word is registered into the two-word queue and its result is registered in
// the FIFO back end. The back end's single RAM port pair (one push or one pop
// a cycle) sets the rate. Reset clears the queue, pointers, countdown and mask
// and restores the keymap and delays; the character RAM needs no clearing.
// An output stall fills the queue, after which in_ready_o drops.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_with_repeat
  import kpr_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [MASK_W-1:0]     row_sense_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CHAR_W-1:0]     out_char_o,
  output logic                  char_valid_o,
  output logic                  key_accepted_o,
  output logic                  key_dropped_o,
  output logic [LEVEL_W-1:0]    fifo_level_o,
  output logic [MASK_W-1:0]     pressed_keys_o
);

  logic     fr_valid, fr_ready;
  kpr_op_t  fr_op;
  logic     bk_valid, bk_ready;
  kpr_op_t  bk_op;
  kpr_res_t res;

  kpr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .row_sense_i (row_sense_i),
    .op_valid_o  (fr_valid),
    .op_o        (fr_op),
    .op_ready_i  (fr_ready)
  );

  kpr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_data_i  (fr_op),
    .push_ready_o (fr_ready),
    .pop_valid_o  (bk_valid),
    .pop_data_o   (bk_op),
    .pop_ready_i  (bk_ready)
  );

  kpr_back #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (bk_valid),
    .op_i        (bk_op),
    .op_ready_o  (bk_ready),
    .res_valid_o (out_valid_o),
    .res_o       (res),
    .res_char_o  (out_char_o),
    .res_ready_i (out_ready_i)
  );

  assign char_valid_o   = res.char_valid;
  assign key_accepted_o = res.key_accepted;
  assign key_dropped_o  = res.key_dropped;
  assign fifo_level_o   = res.level;
  assign pressed_keys_o = res.mask;

endmodule
